// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the core checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic property, clocked and disabled in reset
`define AST_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// overlapping implication
`define AST_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// Types and constants shared by the voice allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mva_pkg;

  localparam int NUM_VOICES = 4;
  localparam int OUT_VOICES = 4;
  localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int LIM_W      = $clog2(NUM_VOICES + 1);
  localparam int VL_RST     = (2 > NUM_VOICES) ? NUM_VOICES : 2;

  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = 3 * BYTE_W;
  localparam int OUT_DATA_W = 2 * OUT_VOICES * BYTE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_CTRL     = 4'hB;
  localparam logic [7:0] ST_STOP      = 8'hFC;

  localparam logic [7:0] CC_ALL_SOUND_OFF = 8'h78;
  localparam logic [7:0] CC_RESET_ALL     = 8'h79;
  localparam logic [7:0] CC_ALL_NOTES_OFF = 8'h7B;
  localparam logic [7:0] CC_OMNI_OFF      = 8'h7C;
  localparam logic [7:0] CC_SUSTAIN       = 8'h40;
  localparam logic [7:0] SUSTAIN_ON_MIN   = 8'd64;

  localparam logic [CFG_IDX_W-1:0] REG_VOICE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEAL_MODE   = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_RETRIG,
    OP_NOTE_ON,
    OP_NOTE_OFF
  } op_t;

  typedef struct packed {
    logic latch;
    logic scan;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== rtl/core/mva_datapath.sv =====
// ----------------------------------------------------------------------------
// mva_datapath
// Voice table, config registers, request latch, one-voice-per-cycle scan
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mva_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mva_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             cfg_valid,
  input  logic [mva_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mva_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  mva_pkg::dp_cmd_t                 cmd,
  output mva_pkg::dp_sts_t                 sts,
  output logic [mva_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser
);
  import mva_pkg::*;

  logic [7:0]       pitch_r [NUM_VOICES];
  logic [7:0]       level_r [NUM_VOICES];
  logic [7:0]       pitch_nxt [NUM_VOICES];
  logic [7:0]       level_nxt [NUM_VOICES];
  logic [LIM_W-1:0] limit_r;
  logic             all_ch_r;
  logic             steal_r;

  op_t              op_r;
  logic [7:0]       p_r;
  logic [7:0]       v_r;
  logic [IDX_W-1:0] idx_r;
  logic [NUM_VOICES-1:0] mask_r;
  logic             match_found_r;
  logic [IDX_W-1:0] match_idx_r;
  logic             empty_found_r;
  logic [IDX_W-1:0] empty_idx_r;
  logic [IDX_W-1:0] vic_idx_r;
  logic [7:0]       vic_p_r;
  logic [7:0]       vic_l_r;

  logic             out_rt_r;
  logic             rt_nxt;
  logic [7:0]       out_pitch_r [OUT_VOICES];
  logic [7:0]       out_level_r [OUT_VOICES];

  logic [7:0]       st_in;
  logic [7:0]       d1_in;
  logic [7:0]       d2_in;
  op_t              op_dec;
  logic             chan_ok;
  logic [7:0]       cur_p;
  logic [7:0]       cur_l;
  logic             in_lim;
  logic             vic_take;
  logic [LIM_W-1:0] cfg_limit;

  assign st_in = in_tdata[7:0];
  assign d1_in = in_tdata[15:8];
  assign d2_in = in_tdata[23:16];

  // message decode
  always_comb begin
    chan_ok = all_ch_r || (st_in[3:1] == 3'd0);
    op_dec  = OP_NONE;
    if (chan_ok) begin
      if (st_in == ST_STOP) begin
        op_dec = OP_CLEAR;
      end else begin
        case (st_in[7:4])
          CMD_NOTE_ON:  op_dec = (d2_in == 8'd0) ? OP_NOTE_OFF : OP_NOTE_ON;
          CMD_NOTE_OFF: op_dec = OP_NOTE_OFF;
          CMD_CTRL: begin
            if (d1_in == CC_ALL_SOUND_OFF || d1_in == CC_RESET_ALL ||
                d1_in == CC_ALL_NOTES_OFF || d1_in == CC_OMNI_OFF) begin
              op_dec = OP_CLEAR;
            end else if (d1_in == CC_SUSTAIN && d2_in < SUSTAIN_ON_MIN) begin
              op_dec = OP_RETRIG;
            end
          end
          default: op_dec = OP_NONE;
        endcase
      end
    end
  end

  assign sts.needs_scan = (op_dec == OP_NOTE_ON) || (op_dec == OP_NOTE_OFF);
  assign sts.scan_last  = (idx_r == IDX_W'(NUM_VOICES - 1));

  assign cur_p    = pitch_r[idx_r];
  assign cur_l    = level_r[idx_r];
  assign in_lim   = (LIM_W'(idx_r) < limit_r);
  assign vic_take = (idx_r == '0) || (cur_p < vic_p_r) ||
                    (cur_p == vic_p_r && cur_l < vic_l_r);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_limit = LIM_W'(1);
    end else if (int'(cfg_data) > NUM_VOICES) begin
      cfg_limit = LIM_W'(NUM_VOICES);
    end else begin
      cfg_limit = LIM_W'(cfg_data);
    end
  end

  // table update for the request being applied
  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      pitch_nxt[i] = pitch_r[i];
      level_nxt[i] = level_r[i];
    end
    rt_nxt = 1'b0;
    case (op_r)
      OP_CLEAR: begin
        for (int i = 0; i < NUM_VOICES; i++) pitch_nxt[i] = 8'd0;
        rt_nxt = 1'b1;
      end
      OP_RETRIG: rt_nxt = 1'b1;
      OP_NOTE_OFF: begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (mask_r[i]) pitch_nxt[i] = 8'd0;
        end
        rt_nxt = |mask_r;
      end
      OP_NOTE_ON: begin
        if (match_found_r) begin
          level_nxt[match_idx_r] = v_r;
          rt_nxt = 1'b1;
        end else if (empty_found_r) begin
          pitch_nxt[empty_idx_r] = p_r;
          level_nxt[empty_idx_r] = v_r;
          rt_nxt = 1'b1;
        end else if (steal_r) begin
          if (v_r > vic_l_r || p_r > vic_p_r) begin
            pitch_nxt[vic_idx_r] = p_r;
            level_nxt[vic_idx_r] = v_r;
            rt_nxt = 1'b1;
          end
        end else begin
          // oldest voice drops out, new note goes on top
          for (int i = 0; i < NUM_VOICES; i++) begin
            if ((i + 1) < int'(limit_r)) begin
              pitch_nxt[i] = pitch_r[(i + 1) % NUM_VOICES];
              level_nxt[i] = level_r[(i + 1) % NUM_VOICES];
            end else if ((i + 1) == int'(limit_r)) begin
              pitch_nxt[i] = p_r;
              level_nxt[i] = v_r;
            end
          end
          rt_nxt = 1'b1;
        end
      end
      default: rt_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        pitch_r[i] <= 8'd0;
        level_r[i] <= 8'd0;
      end
      limit_r       <= LIM_W'(VL_RST);
      all_ch_r      <= 1'b0;
      steal_r       <= 1'b0;
      op_r          <= OP_NONE;
      idx_r         <= '0;
      mask_r        <= '0;
      match_found_r <= 1'b0;
      empty_found_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_VOICE_LIMIT: begin
            limit_r <= cfg_limit;
            for (int i = 0; i < NUM_VOICES; i++) begin
              if (i >= int'(cfg_limit)) pitch_r[i] <= 8'd0;
            end
          end
          REG_ALL_CHANNELS: all_ch_r <= cfg_data[0];
          REG_STEAL_MODE:   steal_r  <= cfg_data[0];
          default: ;
        endcase
      end else if (cmd.apply) begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          pitch_r[i] <= pitch_nxt[i];
          level_r[i] <= level_nxt[i];
        end
      end

      if (cmd.latch) begin
        op_r          <= op_dec;
        idx_r         <= '0;
        mask_r        <= '0;
        match_found_r <= 1'b0;
        empty_found_r <= 1'b0;
      end else if (cmd.scan) begin
        idx_r <= sts.scan_last ? '0 : idx_r + IDX_W'(1);
        if (in_lim) begin
          if (cur_p == p_r) begin
            mask_r[idx_r] <= 1'b1;
            if (!match_found_r) begin
              match_found_r <= 1'b1;
            end
          end
          if (cur_p == 8'd0 && !empty_found_r) begin
            empty_found_r <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      p_r <= d1_in;
      v_r <= d2_in;
    end
    if (cmd.scan && in_lim) begin
      if (cur_p == p_r && !match_found_r) match_idx_r <= idx_r;
      if (cur_p == 8'd0 && !empty_found_r) empty_idx_r <= idx_r;
      if (vic_take) begin
        vic_idx_r <= idx_r;
        vic_p_r   <= cur_p;
        vic_l_r   <= cur_l;
      end
    end
    if (cmd.apply) begin
      out_rt_r <= rt_nxt;
    end
  end

  for (genvar g = 0; g < OUT_VOICES; g++) begin : g_out
    if (g < NUM_VOICES) begin : g_live
      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          out_pitch_r[g] <= pitch_nxt[g];
          out_level_r[g] <= level_nxt[g];
        end
      end
    end else begin : g_absent
      always_ff @(posedge clk) begin
        out_pitch_r[g] <= 8'd0;
        out_level_r[g] <= 8'd0;
      end
    end
    assign out_tdata[g*BYTE_W +: BYTE_W]                = out_pitch_r[g];
    assign out_tdata[(OUT_VOICES+g)*BYTE_W +: BYTE_W]   = out_level_r[g];
  end

  assign out_tuser = out_rt_r;

endmodule

// ===== rtl/core/mva_ctrl.sv =====
// ----------------------------------------------------------------------------
// mva_ctrl
// Sequencer: takes a request, runs the voice scan for note messages, applies the update and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mva_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mva_pkg::dp_sts_t  sts,
  output mva_pkg::dp_cmd_t  cmd
);
  import mva_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.latch     = in_tvalid && in_tready;
    cmd.scan      = (state_r == ST_SCAN);
    cmd.apply     = (state_r == ST_APPLY) && (!out_valid_r || out_tready);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (cmd.latch) state_nxt = sts.needs_scan ? ST_SCAN : ST_APPLY;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (cmd.apply) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/midi_voice_allocator_core.sv =====
// ----------------------------------------------------------------------------
// midi_voice_allocator_core
// Polyphonic voice allocator for three-byte MIDI messages.
//
// in_*  : one message per request, tdata = {data2, data1, status_byte}.
// out_* : one result per message, tdata = voice pitches then levels,
//         tuser = retrigger flag.
// cfg_* : register writes (voice limit, all channels, steal mode); take them
//         only while no message is in flight. cfg_ready is always high.
// Note messages walk the voice table one voice a cycle, then apply the
// update; other messages skip the scan and go straight to the update. A
// new request is taken only after the previous one has been applied.
// The result sits in an output register; a stalled receiver holds it while
// the next request is taken and scanned, and the update waits until the
// register frees.
// Reset empties every voice, zeroes levels, sets voice limit 2 and clears
// both mode bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_voice_allocator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mva_pkg::IN_DATA_W-1:0]    in_tdata,   // status_byte, data1, data2
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // voice0..3_pitch, voice0..3_level
  output logic [mva_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,  // retrigger_timers
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mva_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mva_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mva_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  mva_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mva_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== rtl/core/mva_checker.sv =====
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mva_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mva_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                             out_tuser,
  input logic                             cfg_ready
);

  // stalled result holds
  `AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
            out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // one request at a time
  `AST_NEXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a new result follows a busy cycle
  `AST_IMPL(a_result_from_req, clk, rst_n, $rose(out_tvalid), $past(!in_tready))
  // config port never back-pressures
  `AST_PROP(a_cfg_ready, clk, rst_n, cfg_ready)

endmodule

bind midi_voice_allocator_core mva_checker u_chk (.*);
